/* hdl/msprfp_pkg.sv */
// Shared types and constants for the MSP response frame parser.
package msprfp_pkg;

  // Ceiling on the payload index limit
  localparam logic [7:0] PAYLOAD_LIMIT_MAX = 8'd64;

  // Header characters
  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_M      = 8'h4D;  // 'M'
  localparam logic [7:0] CH_GT     = 8'h3E;  // '>'

  // Configuration register indexes
  localparam logic CFG_EXPECTED_COMMAND = 1'b0;
  localparam logic CFG_MAX_PAYLOAD      = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_OK      = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;

  // Parser phases; the spare code behaves as PH_SKIP
  typedef enum logic [2:0] {
    PH_DOLLAR = 3'd0,
    PH_M      = 3'd1,
    PH_GT     = 3'd2,
    PH_LEN    = 3'd3,
    PH_CMD    = 3'd4,
    PH_BODY   = 3'd5,
    PH_SKIP   = 3'd6
  } phase_t;

  // One result beat
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_length;
    logic       last;
  } result_t;

endpackage

/* hdl/msp_response_frame_parser.sv */
// MSP response frame parser top level: config, input register, core, output register.
//
//  channel  | direction | handshake                   | beat
//  byte     | in        | byte_valid / byte_stall     | data_byte, datagram_end
//  result   | out       | result_valid / result_stall | result_kind, payload_byte,
//           |           |                             | payload_index, frame_length, last
//  cfg      | in        | cfg_write                   | cfg_index, cfg_data
//
// One byte per cycle sustained while result_stall does not hold it; a byte
// goes from the input register through parser logic into the result register.
// rst is synchronous: parser goes to hunting for '$', expected_command to 0,
// max_payload to 64. A stalled result holds the result register; the byte in
// the input register then waits if it yields a result, and byte_stall rises.
module msp_response_frame_parser import msprfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       datagram_end,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] result_kind,
  output logic [7:0] payload_byte,
  output logic [7:0] payload_index,
  output logic [7:0] frame_length,
  output logic       last,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data
);

  logic [7:0] expected_command;
  logic [6:0] max_payload;
  logic       in_full;
  logic [7:0] in_data;
  logic       in_dend;
  logic       step;
  logic       accept;
  logic       res_valid;
  result_t    res;
  logic       out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_command <= '0;
      max_payload      <= 7'd64;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_EXPECTED_COMMAND: expected_command <= cfg_data;
        CFG_MAX_PAYLOAD:      max_payload      <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  // Input byte leaves its register when its result, if any, has room
  assign step       = in_full && (!res_valid || out_free);
  assign byte_stall = in_full && !step;
  assign accept     = byte_valid && !byte_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_data <= data_byte;
      in_dend <= datagram_end;
    end
  end

  msprfp_core u_core (
    .clk              (clk),
    .rst              (rst),
    .step             (step),
    .data             (in_data),
    .dend             (in_dend),
    .expected_command (expected_command),
    .max_payload      (max_payload),
    .res_valid        (res_valid),
    .res              (res)
  );

  msprfp_out_stage u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (step && res_valid),
    .res           (res),
    .result_stall  (result_stall),
    .free          (out_free),
    .result_valid  (result_valid),
    .result_kind   (result_kind),
    .payload_byte  (payload_byte),
    .payload_index (payload_index),
    .frame_length  (frame_length),
    .last          (last)
  );

endmodule

/* hdl/msprfp_core.sv */
// Frame parser state and the per-byte result logic.
module msprfp_core import msprfp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    data,
  input  logic          dend,
  input  logic [7:0]    expected_command,
  input  logic [6:0]    max_payload,
  output logic          res_valid,
  output result_t       res
);

  phase_t     parse_phase, parse_phase_next;
  logic [7:0] declared_length, declared_length_next;
  logic [7:0] frame_command, frame_command_next;
  logic [7:0] bytes_taken, bytes_taken_next;
  logic [7:0] running_check, running_check_next;
  logic [7:0] limit;
  logic       cmd_match;

  // Clamp the configured limit
  assign limit = ({1'b0, max_payload} > PAYLOAD_LIMIT_MAX) ? PAYLOAD_LIMIT_MAX
                                                           : {1'b0, max_payload};
  assign cmd_match = (frame_command == expected_command);

  // Next state and result for the byte in the input register
  always_comb begin
    parse_phase_next     = parse_phase;
    declared_length_next = declared_length;
    frame_command_next   = frame_command;
    bytes_taken_next     = bytes_taken;
    running_check_next   = running_check;
    res_valid            = 1'b0;
    res                  = '0;
    res.frame_length     = declared_length;

    case (parse_phase)
      PH_DOLLAR: begin
        parse_phase_next = (data == CH_DOLLAR) ? PH_M : PH_DOLLAR;
      end
      PH_M: begin
        parse_phase_next = (data == CH_M) ? PH_GT : PH_DOLLAR;
      end
      PH_GT: begin
        parse_phase_next = (data == CH_GT) ? PH_LEN : PH_DOLLAR;
      end
      PH_LEN: begin
        declared_length_next = data;
        running_check_next   = data;
        bytes_taken_next     = '0;
        parse_phase_next     = PH_CMD;
      end
      PH_CMD: begin
        frame_command_next = data;
        running_check_next = running_check ^ data;
        parse_phase_next   = PH_BODY;
      end
      PH_BODY: begin
        if (bytes_taken < declared_length) begin
          running_check_next = running_check ^ data;
          if (cmd_match && (bytes_taken < limit)) begin
            res_valid         = 1'b1;
            res.kind          = KIND_PAYLOAD;
            res.payload_byte  = data;
            res.payload_index = bytes_taken;
          end
          bytes_taken_next = bytes_taken + 8'd1;
        end else begin
          if (cmd_match) begin
            res_valid = 1'b1;
            res.kind  = (running_check == data) ? KIND_OK : KIND_BAD;
            res.last  = 1'b1;
          end
          parse_phase_next = PH_SKIP;
        end
      end
      default: begin
        // skip to end of datagram
      end
    endcase

    // Datagram end drops any frame in progress
    if (dend) begin
      parse_phase_next     = PH_DOLLAR;
      declared_length_next = '0;
      frame_command_next   = '0;
      bytes_taken_next     = '0;
      running_check_next   = '0;
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_DOLLAR;
      declared_length <= '0;
      frame_command   <= '0;
      bytes_taken     <= '0;
      running_check   <= '0;
    end else if (step) begin
      parse_phase     <= parse_phase_next;
      declared_length <= declared_length_next;
      frame_command   <= frame_command_next;
      bytes_taken     <= bytes_taken_next;
      running_check   <= running_check_next;
    end
  end

  // End results carry a checksum verdict, never a payload kind
  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last |-> (res.kind == KIND_OK) || (res.kind == KIND_BAD))
    else $error("end result with payload kind");

  // Payload results stay under the clamped limit
  a_pay_limit: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |-> (res.payload_index < limit))
    else $error("payload index beyond limit");

  // A datagram end always leaves the parser hunting with a clean count
  a_dend_clear: assert property (@(posedge clk) disable iff (rst)
    step && dend |=> (parse_phase == PH_DOLLAR) && (bytes_taken == 8'd0)
                     && (running_check == 8'd0))
    else $error("datagram end did not clear parser");

  // Only the body phase yields results
  a_res_phase: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (parse_phase == PH_BODY))
    else $error("result outside body phase");

endmodule

/* hdl/msprfp_out_stage.sv */
// Output result register with valid/stall handshake.
module msprfp_out_stage import msprfp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  result_t       res,
  input  logic          result_stall,
  output logic          free,
  output logic          result_valid,
  output logic [1:0]    result_kind,
  output logic [7:0]    payload_byte,
  output logic [7:0]    payload_index,
  output logic [7:0]    frame_length,
  output logic          last
);

  result_t held;

  // Register may take a new beat when empty or being drained
  assign free = !result_valid || !result_stall;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

  assign result_kind   = held.kind;
  assign payload_byte  = held.payload_byte;
  assign payload_index = held.payload_index;
  assign frame_length  = held.frame_length;
  assign last          = held.last;

endmodule

/* verif/msprfp_checker.sv */
// Scoreboard for the MSP response frame parser: predicts result beats and compares them.
`timescale 1ns / 100ps
module msprfp_checker import msprfp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  input  logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       datagram_end,
  input  logic       result_valid,
  input  logic       result_stall,
  input  logic [1:0] result_kind,
  input  logic [7:0] payload_byte,
  input  logic [7:0] payload_index,
  input  logic [7:0] frame_length,
  input  logic       last,
  input  logic       cfg_write,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  output int         error_count,
  output int         pending_count
);

  // Shadow parser state and registers
  phase_t     phase;
  logic [7:0] frame_len;
  logic [7:0] frame_cmd;
  logic [7:0] taken;
  logic [7:0] check_acc;
  logic [7:0] want_cmd;
  logic [6:0] payload_cap;

  result_t expected_beats[$];
  result_t got;
  result_t want;
  int      mismatches = 0;

  assign error_count = mismatches;

  task automatic drop_frame();
    phase     = PH_DOLLAR;
    frame_len = 8'd0;
    frame_cmd = 8'd0;
    taken     = 8'd0;
    check_acc = 8'd0;
  endtask

  // Advance the shadow parser by one byte; queue the beat it yields, if any
  task automatic parse_byte(input logic [7:0] c, input logic dend);
    logic [7:0] limit;
    result_t    r;
    limit = ({1'b0, payload_cap} > PAYLOAD_LIMIT_MAX) ? PAYLOAD_LIMIT_MAX
                                                      : {1'b0, payload_cap};
    r = '0;
    case (phase)
      PH_DOLLAR: phase = (c == CH_DOLLAR) ? PH_M : PH_DOLLAR;
      PH_M:      phase = (c == CH_M) ? PH_GT : PH_DOLLAR;
      PH_GT:     phase = (c == CH_GT) ? PH_LEN : PH_DOLLAR;
      PH_LEN: begin
        frame_len = c;
        check_acc = c;
        taken     = 8'd0;
        phase     = PH_CMD;
      end
      PH_CMD: begin
        frame_cmd = c;
        check_acc = check_acc ^ c;
        phase     = PH_BODY;
      end
      PH_BODY: begin
        if (taken < frame_len) begin
          check_acc = check_acc ^ c;
          if (frame_cmd == want_cmd && taken < limit) begin
            r.kind          = KIND_PAYLOAD;
            r.payload_byte  = c;
            r.payload_index = taken;
            r.frame_length  = frame_len;
            r.last          = 1'b0;
            expected_beats.push_back(r);
          end
          taken = taken + 8'd1;
        end else begin
          // checksum byte closes the frame
          if (frame_cmd == want_cmd) begin
            r.kind         = (check_acc == c) ? KIND_OK : KIND_BAD;
            r.frame_length = frame_len;
            r.last         = 1'b1;
            expected_beats.push_back(r);
          end
          phase = PH_SKIP;
        end
      end
      default: ;  // skip to end of datagram
    endcase
    if (dend) drop_frame();
  endtask

  task automatic compare_field(input string what, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Watch both channels and the register port on every edge
  always @(posedge clk) begin
    if (rst) begin
      want_cmd    = 8'd0;
      payload_cap = 7'd64;
      drop_frame();
      expected_beats.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_EXPECTED_COMMAND) want_cmd = cfg_data;
        else if (cfg_index == CFG_MAX_PAYLOAD) payload_cap = cfg_data[6:0];
      end
      if (result_valid && !result_stall) begin
        got.kind          = result_kind;
        got.payload_byte  = payload_byte;
        got.payload_index = payload_index;
        got.frame_length  = frame_length;
        got.last          = last;
        if (expected_beats.size() == 0) begin
          $display({"%0t ns: unexpected result beat, expected none, ",
                    "actual kind %0d byte %0d index %0d length %0d last %0d"},
                   $time, got.kind, got.payload_byte, got.payload_index, got.frame_length,
                   got.last);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          compare_field("result_kind", {6'd0, want.kind}, {6'd0, got.kind});
          compare_field("payload_byte", want.payload_byte, got.payload_byte);
          compare_field("payload_index", want.payload_index, got.payload_index);
          compare_field("frame_length", want.frame_length, got.frame_length);
          compare_field("last", {7'd0, want.last}, {7'd0, got.last});
        end
      end
      if (byte_valid && !byte_stall) parse_byte(data_byte, datagram_end);
    end
    pending_count <= expected_beats.size();
  end

endmodule

/* verif/tb.sv */
// Top-level testbench for the MSP response frame parser: stimulus, handshakes and verdict.
`timescale 1ns / 100ps
module tb;
  import msprfp_pkg::*;

  logic       clk = 1'b0;
  logic       rst;
  logic       byte_valid;
  logic       byte_stall;
  logic [7:0] data_byte;
  logic       datagram_end;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [1:0] result_kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic [7:0] frame_length;
  logic       last;
  logic       cfg_write;
  logic       cfg_index;
  logic [7:0] cfg_data;

  int fails;
  int pending;
  int frame_bytes;
  bit tx_burst = 1'b0;
  bit rx_calm  = 1'b0;
  int stall_hold = 0;
  int stall_draw;

  always #6 clk = ~clk;

  msp_response_frame_parser uut (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_stall(byte_stall),
    .data_byte(data_byte), .datagram_end(datagram_end),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_kind(result_kind), .payload_byte(payload_byte),
    .payload_index(payload_index), .frame_length(frame_length), .last(last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  msprfp_checker watch (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_stall(byte_stall),
    .data_byte(data_byte), .datagram_end(datagram_end),
    .result_valid(result_valid), .result_stall(result_stall),
    .result_kind(result_kind), .payload_byte(payload_byte),
    .payload_index(payload_index), .frame_length(frame_length), .last(last),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .error_count(fails), .pending_count(pending)
  );

  // Result side back-pressure: hold off a random number of cycles after each beat
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_hold   <= 0;
    end else if (stall_hold > 0) begin
      result_stall <= 1'b1;
      stall_hold   <= stall_hold - 1;
    end else if (result_valid && !result_stall) begin
      if ($urandom_range(0, 29) == 0) rx_calm <= !rx_calm;
      stall_draw    = rx_calm ? 0 : $urandom_range(0, 19);
      result_stall <= (stall_draw != 0);
      stall_hold   <= (stall_draw > 0) ? stall_draw - 1 : 0;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // One byte beat, after a random gap; valid stays high across back-to-back beats
  task automatic send_byte(input logic [7:0] b, input logic dend);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid   <= 1'b1;
    data_byte    <= b;
    datagram_end <= dend;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
  endtask

  // Drain: wait until every predicted beat is back and the pipeline is empty
  task automatic settle();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] cmd, input logic [7:0] cap_raw);
    cfg_write <= 1'b1;
    cfg_index <= CFG_EXPECTED_COMMAND;
    cfg_data  <= cmd;
    @(posedge clk);
    cfg_index <= CFG_MAX_PAYLOAD;
    cfg_data  <= cap_raw;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // One datagram: optional leading noise, header, length, command, payload,
  // checksum, optional trailing noise; sometimes corrupted, cut short or left open
  task automatic send_datagram(input logic [7:0] cmd_hit);
    logic [7:0] frame[$];
    logic [7:0] len;
    logic [7:0] cmd;
    logic [7:0] sum;
    logic [7:0] b;
    int         lead;
    int         body_end;
    int         cut;
    int         hi;
    int         i;
    bit         close;
    tx_burst = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
    lead = frame.size();
    frame.push_back(CH_DOLLAR);
    frame.push_back(CH_M);
    frame.push_back(CH_GT);
    if ($urandom_range(0, 9) == 0) frame[lead + $urandom_range(0, 2)] = 8'($urandom);
    case ($urandom_range(0, 14))
      0:       len = 8'($urandom_range(65, 255));
      1, 2:    len = 8'($urandom_range(9, 70));
      default: len = 8'($urandom_range(0, 8));
    endcase
    cmd = ($urandom_range(0, 4) != 0) ? cmd_hit : 8'($urandom);
    frame.push_back(len);
    frame.push_back(cmd);
    sum = len ^ cmd;
    for (i = 0; i < len; i++) begin
      b = 8'($urandom);
      sum = sum ^ b;
      frame.push_back(b);
    end
    body_end = frame.size();
    frame.push_back(($urandom_range(0, 3) != 0) ? sum : sum ^ 8'($urandom_range(1, 255)));
    if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) frame.push_back(8'($urandom));
    cut   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, frame.size() - 1) : frame.size() - 1;
    close = ($urandom_range(0, 7) != 0);
    for (i = 0; i <= cut; i++) send_byte(frame[i], close && i == cut);
    // only header-to-checksum bytes count towards the budget
    hi = (cut < body_end) ? cut : body_end;
    if (hi >= lead) frame_bytes += hi - lead + 1;
  endtask

  // Stimulus
  initial begin
    int         p;
    logic [7:0] cmd_sel;
    logic [7:0] cap_raw;
    rst          <= 1'b1;
    byte_valid   <= 1'b0;
    data_byte    <= 8'd0;
    datagram_end <= 1'b0;
    cfg_write    <= 1'b0;
    cfg_index    <= CFG_EXPECTED_COMMAND;
    cfg_data     <= 8'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset registers: zero-length frame, then a skipped byte ending the datagram
    send_byte(CH_DOLLAR, 1'b0); send_byte(CH_M, 1'b0); send_byte(CH_GT, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    // header mismatch: the second '$' must not restart the header
    send_byte(CH_DOLLAR, 1'b0); send_byte(CH_DOLLAR, 1'b0);
    send_byte(CH_M, 1'b0); send_byte(CH_GT, 1'b0);
    // two payload beats with extreme values, then a bad checksum
    send_byte(CH_DOLLAR, 1'b0); send_byte(CH_M, 1'b0); send_byte(CH_GT, 1'b0);
    send_byte(8'h02, 1'b0); send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b1);
    // other command: silent even with a good checksum
    send_byte(CH_DOLLAR, 1'b0); send_byte(CH_M, 1'b0); send_byte(CH_GT, 1'b0);
    send_byte(8'h01, 1'b0); send_byte(8'h07, 1'b0);
    send_byte(8'hAA, 1'b0); send_byte(8'hAC, 1'b1);
    settle();

    // Random phases over a spread of register settings
    for (p = 0; p < 6; p++) begin
      case (p)
        0:       begin cmd_sel = 8'hFF;         cap_raw = 8'd0;   end
        1:       begin cmd_sel = 8'($urandom);  cap_raw = 8'd1;   end
        2:       begin cmd_sel = 8'h00;         cap_raw = 8'h7F;  end  // above ceiling
        3:       begin cmd_sel = 8'($urandom);  cap_raw = 8'd64;  end
        4:       begin cmd_sel = 8'($urandom);  cap_raw = 8'hC1;  end  // top bit dropped: 65
        default: begin cmd_sel = 8'($urandom);  cap_raw = 8'($urandom_range(2, 63)); end
      endcase
      program_regs(cmd_sel, cap_raw);
      frame_bytes = 0;
      while (frame_bytes < 40) send_datagram(cmd_sel);
      settle();
    end

    if (fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
